[hdl/indexed_sequence_list_unit_assert.svh]
// Assertion helpers for the list unit. Each one is clocked on clock and
// disabled while reset is high.
`ifndef INDEXED_SEQUENCE_LIST_UNIT_ASSERT_SVH
`define INDEXED_SEQUENCE_LIST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISL_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("list unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("list unit: next-cycle check failed");

`endif

[hdl/isl_pkg.sv]
package isl_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 9;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   // Stream packing: request tdata = position, value; response tdata =
   // read_value, element_count. Both padded to whole bytes.
   localparam int REQ_FIELDS_W = POS_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = DATA_W + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_READ       = 3'd6;
   localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd7;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_UP,
      S_DOWN,
      S_DRAIN,
      S_PUT,
      S_FINISH
   } state_type;

endpackage

[hdl/indexed_sequence_list_unit.sv]
// Bounded ordered list of signed 32-bit values held in one on-chip memory.
// Requests arrive on the req_ stream channel: req_tuser carries the request
// kind and req_tdata carries the position and the value. Every request
// transaction produces exactly one response transaction on the rsp_ channel,
// with the read value and new element count in rsp_tdata and the status in
// rsp_tuser.
// The unit works on one request at a time: it decodes the request, moves
// entries if needed (up one place for an insert or push, down one place for
// an erase or pop, then a drain step), stores the value for an insert, push
// or write, and loads the response. A read or a rejected request moves and
// stores nothing. The entries move one per cycle through the single read and
// single write port of the memory. After the response is loaded the unit
// returns to idle, where it accepts the next request.
// A response waits in an output register while the receiver stalls; the
// next request is still accepted and worked on, and its response is held
// back until the register is free.
// Reset clears the element count and the control state only. The memory
// needs no clearing pass: no request can reach an entry at or beyond the
// count, so stale contents are never observed.
module indexed_sequence_list_unit #(
   parameter int DEPTH = isl_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata, from bit 0: position[8:0], value[40:9], zero fill.
   input  logic [isl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser, from bit 0: req_type[2:0].
   input  logic [isl_pkg::KIND_W-1:0]      req_tuser,
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata, from bit 0: read_value[31:0], element_count[40:32], zero fill.
   output logic [isl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser, from bit 0: status[1:0].
   output logic [isl_pkg::STATUS_W-1:0]    rsp_tuser
);

`include "indexed_sequence_list_unit_assert.svh"

   // Address width for the memory, count width able to hold DEPTH itself,
   // and a common width for comparing the 9-bit position with the count.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;
   localparam int RSP_PAD_W = isl_pkg::RSP_TDATA_W - isl_pkg::RSP_FIELDS_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   isl_pkg::state_type state_ff, state_in;

   // Captured request.
   logic [isl_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [isl_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [isl_pkg::DATA_W-1:0]   val_ff, val_in;

   // Plan for the request, settled in the decode cycle.
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                new_count_ff, new_count_in;
   logic [isl_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         is_read_ff, is_read_in;
   logic                         is_open_ff, is_open_in;
   logic [AW-1:0]                at_ff, at_in;

   // Shift walker: the next entry to read, and the write-back of the entry
   // read in the previous cycle.
   logic [AW-1:0]                src_ff, src_in;
   logic [AW-1:0]                wa_ff, wa_in;
   logic                         pend_ff, pend_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [isl_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [isl_pkg::STATUS_W-1:0] rsp_user_ff, rsp_user_in;

   // Memory port.
   logic                         mem_we, mem_re;
   logic [AW-1:0]                mem_wa, mem_ra;
   logic [isl_pkg::DATA_W-1:0]   mem_wd, mem_rd;

   // Decode results.
   logic [isl_pkg::STATUS_W-1:0] dec_status;
   logic                         dec_open, dec_close, dec_read, dec_write;
   logic [AW-1:0]                dec_at;

   logic [EW-1:0]                pos_ext, cnt_ext, new_count_ext;
   logic [CW-1:0]                cnt_m1;
   logic                         full, empty, pos_ge, pos_gt;
   logic                         out_free, last_up, last_down;

   assign pos_ext       = EW'(pos_ff);
   assign cnt_ext       = EW'(count_ff);
   assign new_count_ext = EW'(new_count_ff);
   assign cnt_m1        = count_ff - 1'b1;
   assign full          = (count_ff == DEPTH_C);
   assign empty         = (count_ff == '0);
   assign pos_ge        = (pos_ext >= cnt_ext);
   assign pos_gt        = (pos_ext > cnt_ext);
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign last_up       = (src_ff == at_ff);
   assign last_down     = (CW'(src_ff) == cnt_m1);

   // Classify the captured request against the current count. An open makes
   // a gap at dec_at, a close removes the entry at dec_at.
   always_comb begin
      dec_status = isl_pkg::STATUS_OK;
      dec_open   = 1'b0;
      dec_close  = 1'b0;
      dec_read   = 1'b0;
      dec_write  = 1'b0;
      dec_at     = '0;
      case (kind_ff)
         isl_pkg::KIND_PUSH_FRONT: begin
            if (full) dec_status = isl_pkg::STATUS_FULL;
            else dec_open = 1'b1;
         end
         isl_pkg::KIND_PUSH_BACK: begin
            dec_at = count_ff[AW-1:0];
            if (full) dec_status = isl_pkg::STATUS_FULL;
            else dec_open = 1'b1;
         end
         isl_pkg::KIND_INSERT: begin
            dec_at = pos_ext[AW-1:0];
            if (pos_gt) dec_status = isl_pkg::STATUS_RANGE;
            else if (full) dec_status = isl_pkg::STATUS_FULL;
            else dec_open = 1'b1;
         end
         isl_pkg::KIND_POP_FRONT: begin
            if (empty) dec_status = isl_pkg::STATUS_EMPTY;
            else dec_close = 1'b1;
         end
         isl_pkg::KIND_POP_BACK: begin
            dec_at = cnt_m1[AW-1:0];
            if (empty) dec_status = isl_pkg::STATUS_EMPTY;
            else dec_close = 1'b1;
         end
         isl_pkg::KIND_ERASE: begin
            dec_at = pos_ext[AW-1:0];
            if (pos_ge) dec_status = isl_pkg::STATUS_RANGE;
            else dec_close = 1'b1;
         end
         isl_pkg::KIND_READ: begin
            dec_at = pos_ext[AW-1:0];
            if (pos_ge) dec_status = isl_pkg::STATUS_RANGE;
            else dec_read = 1'b1;
         end
         default: begin
            dec_at = pos_ext[AW-1:0];
            if (pos_ge) dec_status = isl_pkg::STATUS_RANGE;
            else dec_write = 1'b1;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isl_pkg::S_IDLE: begin
            if (req_tvalid) state_in = isl_pkg::S_DECODE;
         end
         isl_pkg::S_DECODE: begin
            if (dec_open) begin
               // Opening at the count moves nothing.
               state_in = (CW'(dec_at) == count_ff) ? isl_pkg::S_PUT : isl_pkg::S_UP;
            end else if (dec_close) begin
               // Closing the last entry moves nothing.
               state_in = (CW'(dec_at) == cnt_m1) ? isl_pkg::S_FINISH : isl_pkg::S_DOWN;
            end else if (dec_write) begin
               state_in = isl_pkg::S_PUT;
            end else begin
               state_in = isl_pkg::S_FINISH;
            end
         end
         isl_pkg::S_UP: begin
            if (last_up) state_in = isl_pkg::S_DRAIN;
         end
         isl_pkg::S_DOWN: begin
            if (last_down) state_in = isl_pkg::S_DRAIN;
         end
         isl_pkg::S_DRAIN: begin
            state_in = is_open_ff ? isl_pkg::S_PUT : isl_pkg::S_FINISH;
         end
         isl_pkg::S_PUT: begin
            state_in = isl_pkg::S_FINISH;
         end
         isl_pkg::S_FINISH: begin
            if (out_free) state_in = isl_pkg::S_IDLE;
         end
         default: begin
            state_in = isl_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      new_count_in = new_count_ff;
      status_in    = status_ff;
      is_read_in   = is_read_ff;
      is_open_in   = is_open_ff;
      at_in        = at_ff;
      src_in       = src_ff;
      wa_in        = wa_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      mem_re       = 1'b0;
      mem_ra       = src_ff;

      // A pending write-back always has the port; otherwise only the final
      // value store uses it.
      mem_we = pend_ff || (state_ff == isl_pkg::S_PUT);
      mem_wa = pend_ff ? wa_ff : at_ff;
      mem_wd = pend_ff ? mem_rd : val_ff;

      case (state_ff)
         isl_pkg::S_IDLE: begin
            req_tready = 1'b1;
            kind_in    = req_tuser;
            pos_in     = req_tdata[isl_pkg::POS_W-1:0];
            val_in     = req_tdata[isl_pkg::REQ_FIELDS_W-1:isl_pkg::POS_W];
         end
         isl_pkg::S_DECODE: begin
            status_in  = dec_status;
            is_read_in = dec_read;
            is_open_in = dec_open;
            at_in      = dec_at;
            if (dec_open) begin
               new_count_in = count_ff + 1'b1;
               src_in       = cnt_m1[AW-1:0];
            end else if (dec_close) begin
               new_count_in = cnt_m1;
               src_in       = dec_at + 1'b1;
            end else begin
               new_count_in = count_ff;
            end
            // A read is issued here; its data holds in the memory's output
            // register until the response is loaded.
            mem_re = dec_read;
            mem_ra = dec_at;
         end
         isl_pkg::S_UP: begin
            mem_re  = 1'b1;
            pend_in = 1'b1;
            wa_in   = src_ff + 1'b1;
            src_in  = src_ff - 1'b1;
         end
         isl_pkg::S_DOWN: begin
            mem_re  = 1'b1;
            pend_in = 1'b1;
            wa_in   = src_ff - 1'b1;
            src_in  = src_ff + 1'b1;
         end
         isl_pkg::S_FINISH: begin
            if (out_free) begin
               count_in     = new_count_ff;
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}},
                               new_count_ext[isl_pkg::COUNT_W-1:0],
                               (is_read_ff ? mem_rd : {isl_pkg::DATA_W{1'b0}})};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isl_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      new_count_ff <= new_count_in;
      status_ff    <= status_in;
      is_read_ff   <= is_read_in;
      is_open_ff   <= is_open_in;
      at_ff        <= at_in;
      src_ff       <= src_in;
      wa_ff        <= wa_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   isl_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // While entries move, the write-back never lands on the entry being read.
   `ISL_ASSERT_IMPLIES(a_no_same_entry, mem_we && mem_re, mem_wa != mem_ra)
   // No write-back is left over once the unit is ready for a new request.
   `ISL_ASSERT_IMPLIES(a_idle_no_pending, state_ff == isl_pkg::S_IDLE, !pend_ff)
   // A loaded response is offered, and the count it leaves is at most DEPTH.
   `ISL_ASSERT_NEXT(a_count_reported, (state_ff == isl_pkg::S_FINISH) && out_free,
                    rsp_tvalid && (count_ff <= DEPTH_C))

endmodule

[hdl/isl_mem.sv]
// Single-port-write, single-port-read entry store. Read data is registered
// and holds its value until the next read.
module isl_mem #(
   parameter int DEPTH = isl_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [isl_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [isl_pkg::DATA_W-1:0] rd_data
);

   logic [isl_pkg::DATA_W-1:0] mem [DEPTH];
   logic [isl_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
